@@ design/fca_pkg.sv @@
// Package for the FAT16 cluster allocator: field widths, codes and the
// record that travels from the front to the back. No dependencies.
package fca_pkg;

  localparam int unsigned CLUSTER_W = 10;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned DATA_W    = 16;

  localparam logic [DATA_W-1:0] END_OF_CHAIN = 16'hFFFF;
  localparam logic [DATA_W-1:0] FREE_ENTRY   = 16'h0000;
  localparam int unsigned       FIRST_DATA   = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_BAD_CHAIN = 2'd2
  } status_e;

  // Work class decided by the front.
  typedef enum logic [1:0] {
    K_ALLOC,
    K_FREE,
    K_REJECT
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [CLUSTER_W-1:0] start;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

@@ design/fca_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fca_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/fca_front.sv @@
// Front of the allocator: classifies each command and holds it in a
// two-entry queue for the back. Depends on fca_pkg.
module fca_front #(
  parameter int unsigned ENTRIES = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  logic                            command_i,
  input  logic [fca_pkg::CLUSTER_W-1:0]   start_cluster_i,
  input  logic                            pop_i,
  output fca_pkg::queue_head_t            head_o,
  output logic                            full_o
);
  import fca_pkg::*;

  localparam int unsigned DEPTH = 2;

  cmd_t       slot_q [DEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  cmd_t       cmd_in;
  logic       bad_start;

  // Reserved or out-of-range start never touches the table.
  assign bad_start = (start_cluster_i < CLUSTER_W'(FIRST_DATA)) ||
                     (17'(start_cluster_i) >= 17'(ENTRIES));

  always_comb begin
    cmd_in.start = start_cluster_i;
    if (command_i == CMD_ALLOC) begin
      cmd_in.kind = K_ALLOC;
    end else if (bad_start) begin
      cmd_in.kind = K_REJECT;
    end else begin
      cmd_in.kind = K_FREE;
    end
  end

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.cmd   = slot_q[rd_ptr_q];
  assign full_o       = (count_q == 2'(DEPTH));

endmodule

@@ design/fca_back.sv @@
// Back of the allocator: owns the cluster table RAM, runs the clearing
// pass, the allocate scan and the chain walk. Depends on fca_pkg, fca_ram.
module fca_back #(
  parameter int unsigned ENTRIES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fca_pkg::queue_head_t          head_i,
  output logic                          pop_o,
  output logic                          clearing_o,
  output logic                          done_o,
  output logic [fca_pkg::CLUSTER_W-1:0] cluster_o,
  output logic [fca_pkg::STATUS_W-1:0]  status_o,
  output logic [fca_pkg::COUNT_W-1:0]   freed_count_o
);
  import fca_pkg::*;

  localparam int unsigned AW   = $clog2(ENTRIES);
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE
  } state_e;

  state_e               state_q, state_d;
  logic [AW-1:0]        ptr_q, ptr_d;
  logic [AW-1:0]        chk_q, chk_d;
  logic [AW-1:0]        cur_q, cur_d;
  logic                 pend_q, pend_d;
  logic                 first_q, first_d;
  logic                 fwd_q, fwd_d;
  logic [COUNT_W-1:0]   cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [CLUSTER_W-1:0] cluster_q, cluster_d;
  status_e              status_q, status_d;
  logic [COUNT_W-1:0]   freed_q, freed_d;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [DATA_W-1:0]    wdata;
  logic [AW-1:0]        raddr;
  logic [DATA_W-1:0]    rdata;
  logic [DATA_W-1:0]    link;
  logic                 link_ok;
  logic [COUNT_W-1:0]   cnt_inc;

  fca_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // A link that points back at the entry just cleared reads as free.
  assign link    = fwd_q ? FREE_ENTRY : rdata;
  assign link_ok = (link >= DATA_W'(FIRST_DATA)) && (17'(link) < 17'(ENTRIES));
  assign cnt_inc = cnt_q + 1'b1;

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    chk_d     = chk_q;
    cur_d     = cur_q;
    pend_d    = pend_q;
    first_d   = first_q;
    fwd_d     = fwd_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    cluster_d = cluster_q;
    status_d  = status_q;
    freed_d   = freed_q;
    we        = 1'b0;
    waddr     = cur_q;
    wdata     = FREE_ENTRY;
    raddr     = ptr_q;
    pop_o     = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = ptr_q;
        wdata = (ptr_q < AW'(FIRST_DATA)) ? END_OF_CHAIN : FREE_ENTRY;
        if (ptr_q == LAST) begin
          state_d = S_IDLE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          unique case (head_i.cmd.kind)
            K_ALLOC: begin
              ptr_d   = AW'(FIRST_DATA);
              pend_d  = 1'b0;
              state_d = S_SCAN;
            end
            K_FREE: begin
              cur_d   = AW'(head_i.cmd.start);
              pend_d  = 1'b0;
              first_d = 1'b1;
              fwd_d   = 1'b0;
              cnt_d   = '0;
              state_d = S_FREE;
            end
            default: begin
              done_d    = 1'b1;
              cluster_d = '0;
              status_d  = ST_BAD_CHAIN;
              freed_d   = '0;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Read one entry a cycle, check the one read the cycle before.
        raddr  = ptr_q;
        pend_d = 1'b1;
        chk_d  = ptr_q;
        if (ptr_q != LAST) begin
          ptr_d = ptr_q + 1'b1;
        end
        if (pend_q) begin
          if (rdata == FREE_ENTRY) begin
            we        = 1'b1;
            waddr     = chk_q;
            wdata     = END_OF_CHAIN;
            done_d    = 1'b1;
            cluster_d = CLUSTER_W'(chk_q);
            status_d  = ST_OK;
            freed_d   = '0;
            state_d   = S_IDLE;
          end else if (chk_q == LAST) begin
            done_d    = 1'b1;
            cluster_d = '0;
            status_d  = ST_NO_FREE;
            freed_d   = '0;
            state_d   = S_IDLE;
          end
        end
      end

      S_FREE: begin
        raddr = cur_q;
        if (!pend_q) begin
          pend_d = 1'b1;
          fwd_d  = 1'b0;
        end else if (first_q && link == FREE_ENTRY) begin
          done_d    = 1'b1;
          cluster_d = '0;
          status_d  = ST_BAD_CHAIN;
          freed_d   = '0;
          state_d   = S_IDLE;
        end else begin
          // Clear the current entry while the next link is read.
          we      = 1'b1;
          waddr   = cur_q;
          wdata   = FREE_ENTRY;
          first_d = 1'b0;
          cnt_d   = cnt_inc;
          if (link == END_OF_CHAIN) begin
            done_d    = 1'b1;
            cluster_d = '0;
            status_d  = ST_OK;
            freed_d   = cnt_inc;
            state_d   = S_IDLE;
          end else if (!link_ok) begin
            done_d    = 1'b1;
            cluster_d = '0;
            status_d  = ST_BAD_CHAIN;
            freed_d   = cnt_inc;
            state_d   = S_IDLE;
          end else begin
            cur_d = AW'(link);
            raddr = AW'(link);
            fwd_d = (AW'(link) == cur_q);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      ptr_q     <= '0;
      pend_q    <= 1'b0;
      first_q   <= 1'b0;
      fwd_q     <= 1'b0;
      done_q    <= 1'b0;
      chk_q     <= '0;
      cur_q     <= '0;
      cnt_q     <= '0;
      cluster_q <= '0;
      status_q  <= ST_OK;
      freed_q   <= '0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      pend_q    <= pend_d;
      first_q   <= first_d;
      fwd_q     <= fwd_d;
      done_q    <= done_d;
      chk_q     <= chk_d;
      cur_q     <= cur_d;
      cnt_q     <= cnt_d;
      cluster_q <= cluster_d;
      status_q  <= status_d;
      freed_q   <= freed_d;
    end
  end

  assign clearing_o    = (state_q == S_CLEAR);
  assign done_o        = done_q;
  assign cluster_o     = cluster_q;
  assign status_o      = status_q;
  assign freed_count_o = freed_q;

endmodule

@@ design/fat_cluster_allocator_top.sv @@
// Top level of the FAT16 cluster allocator: front classifier and queue,
// back engine with the cluster table. Depends on fca_pkg, fca_front, fca_back.
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+---------------------------------
//  command   | start (in), busy (out)        | command_i, start_cluster_i
//  result    | done_o strobe, one cycle      | cluster_o, status_o, freed_count_o
//
// A command is taken at an edge with start high and busy low. The front
// queues up to two commands, so a new one can be taken while the back works.
// Allocate scans the table from index 2 up to the first free entry, an
// entry a cycle through the one table read port. Free walks the chain one
// link a cycle, again one table read a cycle.
// After reset the back clears the table; busy stays high
// meanwhile. Results come out in command order and cannot be held off.
module fat_cluster_allocator_top #(
  parameter int unsigned ENTRIES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          command_i,
  input  logic [fca_pkg::CLUSTER_W-1:0] start_cluster_i,
  output logic                          done_o,
  output logic [fca_pkg::CLUSTER_W-1:0] cluster_o,
  output logic [fca_pkg::STATUS_W-1:0]  status_o,
  output logic [fca_pkg::COUNT_W-1:0]   freed_count_o
);
  import fca_pkg::*;

  queue_head_t head;
  logic        pop;
  logic        full;
  logic        clearing;
  logic        push;

  // Hold off commands while the queue is full or the table is being cleared.
  assign busy = full || clearing;
  assign push = start && !busy;

  fca_front #(
    .ENTRIES (ENTRIES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .command_i       (command_i),
    .start_cluster_i (start_cluster_i),
    .pop_i           (pop),
    .head_o          (head),
    .full_o          (full)
  );

  fca_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .clearing_o    (clearing),
    .done_o        (done_o),
    .cluster_o     (cluster_o),
    .status_o      (status_o),
    .freed_count_o (freed_count_o)
  );

endmodule

@@ design/fca_checker.sv @@
// Port-level checks for the FAT16 cluster allocator, bound to the top
// level. Depends on fca_pkg and fat_cluster_allocator_top.
module fca_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          command_i,
  input logic [fca_pkg::CLUSTER_W-1:0] start_cluster_i,
  input logic                          done_o,
  input logic [fca_pkg::CLUSTER_W-1:0] cluster_o,
  input logic [fca_pkg::STATUS_W-1:0]  status_o,
  input logic [fca_pkg::COUNT_W-1:0]   freed_count_o
);
  import fca_pkg::*;

  // Table clearing keeps commands out right after reset.
  a_busy_after_reset: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> busy)
    else $error("busy low right after reset");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ST_OK || status_o == ST_NO_FREE ||
                status_o == ST_BAD_CHAIN))
    else $error("undefined status code");

  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_NO_FREE) |-> (cluster_o == '0 && freed_count_o == '0))
    else $error("full-table result carries data");

  a_alloc_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && cluster_o != '0) |->
      (status_o == ST_OK && freed_count_o == '0 &&
       cluster_o >= CLUSTER_W'(FIRST_DATA)))
    else $error("allocated cluster inconsistent");

endmodule

bind fat_cluster_allocator_top fca_checker u_fca_checker (.*);
